### sv/dwq_pkg.sv
// dwq_pkg: shared types and constants for the deduplicating work queue
// action and status codes, port field widths and parameter defaults
// no dependencies; compile first
package dwq_pkg;

  // field widths fixed by the channel format
  localparam int ACTION_W     = 2;
  localparam int KEY_PORT_W   = 16;
  localparam int STATUS_W     = 3;
  localparam int COUNT_PORT_W = 5;

  // parameter defaults
  localparam int DWQ_CAPACITY = 16;
  localparam int DWQ_KEY_BITS = 16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_CLEAR      = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED   = 3'd0,
    ST_PRESENT = 3'd1,
    ST_FULL    = 3'd2,
    ST_POPPED  = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_CLEARED = 3'd5
  } status_t;

  // per-cycle command to the slot store
  typedef struct packed {
    logic write;    // fill slot at write index, mark occupied
    logic vacate;   // mark slot at read index free
    logic flush;    // mark every slot free
  } dwq_slot_cmd_t;

endpackage

### sv/dwq_ifs.sv
// dwq_ifs: valid/ready channel interfaces of the deduplicating work queue
// dwq_in_if carries requests, dwq_out_if carries results
// depends on dwq_pkg for field widths
interface dwq_in_if import dwq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ACTION_W-1:0]   action;
  logic [KEY_PORT_W-1:0] key_in;

  modport source (output valid, output action, output key_in, input ready);
  modport sink   (input valid, input action, input key_in, output ready);
endinterface

interface dwq_out_if import dwq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [KEY_PORT_W-1:0]   key_out;
  logic [COUNT_PORT_W-1:0] entry_count;

  modport source (output valid, output status, output key_out, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input key_out, input entry_count,
                  output ready);
endinterface

### sv/dwq_key_store.sv
// dwq_key_store: ring slot registers with per-slot occupied flags
// parallel key compare against occupied slots, one read port at the front
// depends on dwq_pkg
module dwq_key_store import dwq_pkg::*; #(
  parameter int CAPACITY = DWQ_CAPACITY,
  parameter int KEY_W    = DWQ_KEY_BITS,
  localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dwq_slot_cmd_t     cmd,
  input  logic [IDX_W-1:0]  wr_idx,
  input  logic [KEY_W-1:0]  wr_key,
  input  logic [IDX_W-1:0]  rd_idx,
  input  logic [KEY_W-1:0]  lookup_key,
  output logic              hit,
  output logic [KEY_W-1:0]  rd_key
);

  logic [KEY_W-1:0]    slot_r [CAPACITY];
  logic [CAPACITY-1:0] occ_r;
  logic [CAPACITY-1:0] occ_nxt;
  logic [CAPACITY-1:0] match;

  // compare against every occupied slot at once
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = occ_r[i] && (slot_r[i] == lookup_key);
    end
  end

  assign hit    = |match;
  assign rd_key = slot_r[rd_idx];

  always_comb begin
    occ_nxt = occ_r;
    if (cmd.flush) begin
      occ_nxt = '0;
    end else begin
      if (cmd.write) begin
        occ_nxt[wr_idx] = 1'b1;
      end
      if (cmd.vacate) begin
        occ_nxt[rd_idx] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      slot_r[wr_idx] <= wr_key;
    end
  end

endmodule

### sv/dedup_work_queue.sv
// dedup_work_queue: ring queue that holds each key at most once
// in_bus requests (action, key_in) -> out_bus results (status, key_out, entry_count)
// push front/back refused as already present on a key match, or as full;
// pop front returns the key and frees it; clear empties the ring
// one request accepted per cycle while out_bus takes results; a result goes
// through the request register, then the result register; the whole compare and
// update of a beat fits between the two; unstalled, throughput is one beat a cycle
// a stalled receiver holds the result register; in_bus.ready stays high until
// the request register is also full, then drops until out_bus takes a beat
// reset (rst_n low, synchronous) empties the queue, front index goes to zero
// and both registers are emptied; slot contents are left unset until pushed
// entry_count reports the number of queued keys after the action
// key_in is taken in its low KEY_BITS bits; key_out is zero except on a pop
// depends on dwq_pkg, dwq_ifs, dwq_key_store
module dedup_work_queue import dwq_pkg::*; #(
  parameter int CAPACITY = DWQ_CAPACITY,
  parameter int KEY_BITS = DWQ_KEY_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  dwq_in_if.sink    in_bus,
  dwq_out_if.source out_bus
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;
  // stored key width: the port never carries more than KEY_PORT_W bits
  localparam int KEY_W = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;

  // request register
  logic              req_vld_r;
  action_t           req_act_r;
  logic [KEY_W-1:0]  req_key_r;

  // queue state
  logic [IDX_W-1:0]  front_r, front_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  // result register
  logic                    res_vld_r;
  status_t                 res_status_r, status_nxt;
  logic [KEY_PORT_W-1:0]   res_key_r, key_out_nxt;
  logic [COUNT_PORT_W-1:0] res_count_r;

  // handshake
  logic in_beat;
  logic advance;

  // slot store hookup
  dwq_slot_cmd_t     slot_cmd;
  logic [IDX_W-1:0]  wr_idx;
  logic              hit;
  logic [KEY_W-1:0]  rd_key;

  // ring arithmetic
  logic [SUM_W-1:0]  back_sum;
  logic [IDX_W-1:0]  back_idx;
  logic [IDX_W-1:0]  front_dec;
  logic [IDX_W-1:0]  front_inc;
  logic              is_full;
  logic              is_empty;

  // request moves on when the result register is free or being emptied
  assign advance      = req_vld_r && (!res_vld_r || out_bus.ready);
  assign in_bus.ready = !req_vld_r || advance;
  assign in_beat      = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else if (in_beat) begin
      req_vld_r <= 1'b1;
    end else if (advance) begin
      req_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      req_act_r <= action_t'(in_bus.action);
      req_key_r <= in_bus.key_in[KEY_W-1:0];
    end
  end

  dwq_key_store #(
    .CAPACITY (CAPACITY),
    .KEY_W    (KEY_W)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (slot_cmd),
    .wr_idx     (wr_idx),
    .wr_key     (req_key_r),
    .rd_idx     (front_r),
    .lookup_key (req_key_r),
    .hit        (hit),
    .rd_key     (rd_key)
  );

  // back slot is front + count, wrapped once at most
  assign back_sum  = SUM_W'(front_r) + SUM_W'(count_r);
  assign back_idx  = (back_sum >= SUM_W'(CAPACITY)) ? IDX_W'(back_sum - SUM_W'(CAPACITY))
                                                    : IDX_W'(back_sum);
  assign front_dec = (front_r == '0) ? IDX_W'(CAPACITY - 1) : front_r - 1'b1;
  assign front_inc = (front_r == IDX_W'(CAPACITY - 1)) ? '0 : front_r + 1'b1;
  assign is_full   = (count_r == CNT_W'(CAPACITY));
  assign is_empty  = (count_r == '0);

  // single-pass decode and state update for the request in the register
  always_comb begin
    front_nxt   = front_r;
    count_nxt   = count_r;
    status_nxt  = ST_CLEARED;
    key_out_nxt = '0;
    slot_cmd    = '0;
    wr_idx      = back_idx;
    case (req_act_r)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (req_act_r == ACT_PUSH_FRONT) begin
          wr_idx = front_dec;
        end
        // a duplicate wins over full
        if (hit) begin
          status_nxt = ST_PRESENT;
        end else if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt     = ST_ADDED;
          slot_cmd.write = advance;
          count_nxt      = count_r + 1'b1;
          if (req_act_r == ACT_PUSH_FRONT) begin
            front_nxt = front_dec;
          end
        end
      end
      ACT_POP_FRONT: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          status_nxt      = ST_POPPED;
          key_out_nxt     = KEY_PORT_W'(rd_key);
          slot_cmd.vacate = advance;
          front_nxt       = front_inc;
          count_nxt       = count_r - 1'b1;
        end
      end
      ACT_CLEAR: begin
        status_nxt     = ST_CLEARED;
        slot_cmd.flush = advance;
        front_nxt      = '0;
        count_nxt      = '0;
      end
      default: begin
        status_nxt = ST_CLEARED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (advance) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  // result register: loads on advance, holds while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (advance) begin
      res_vld_r <= 1'b1;
    end else if (out_bus.ready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_status_r <= status_nxt;
      res_key_r    <= key_out_nxt;
      res_count_r  <= COUNT_PORT_W'(count_nxt);
    end
  end

  assign out_bus.valid       = res_vld_r;
  assign out_bus.status      = res_status_r;
  assign out_bus.key_out     = res_key_r;
  assign out_bus.entry_count = res_count_r;

`ifndef SYNTHESIS
  // count and front stay inside the ring
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CNT_W'(CAPACITY)) && (32'(front_r) < CAPACITY))
    else $error("queue count or front index out of range");

  // an accepted push grows the queue by exactly one
  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && status_nxt == ST_ADDED) |=> (count_r == $past(count_r) + 1'b1))
    else $error("added push did not grow the queue by one");

  // a pop never reports a key from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && status_nxt == ST_POPPED) |-> !is_empty)
    else $error("pop reported on an empty queue");

  // clear leaves the ring empty with the front at slot zero
  a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && req_act_r == ACT_CLEAR) |=> (count_r == '0 && front_r == '0))
    else $error("clear did not empty the ring");
`endif

endmodule
